@@ hdl/yrdb_pkg.sv @@
// ----------------------------------------------------------------------------
// yrdb_pkg: shared definitions for the YUV420 rotate/downscale BGRA block
// Field widths, register map codes, reset values and BT.601 coefficients.
// ----------------------------------------------------------------------------
package yrdb_pkg;

  // Payload field widths.
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned PIXEL_W   = 32;
  localparam int unsigned CFG_W     = 13;

  // APB register map: three 13-bit registers at byte offsets 0, 4 and 8.
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_OUTPUT_STRIDE = 2'd2
  } reg_idx_e;

  // Register reset values.
  localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = 13'd1280;
  localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = 13'd720;
  localparam logic [CFG_W-1:0] OUTPUT_STRIDE_RST = 13'd360;

  // Default frame size limits.
  localparam int unsigned MAX_SOURCE_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_SOURCE_HEIGHT_DEF = 4096;

  // BT.601 limited-range integer coefficients (8 fractional bits).
  localparam logic signed [11:0] COEF_Y   = 12'sd298;
  localparam logic signed [11:0] COEF_RV  = 12'sd409;
  localparam logic signed [11:0] COEF_GU  = 12'sd100;
  localparam logic signed [11:0] COEF_GV  = 12'sd208;
  localparam logic signed [11:0] COEF_BU  = 12'sd516;
  localparam logic [7:0]         ALPHA    = 8'hFF;
  localparam logic [7:0]         LUMA_OFS = 8'd16;
  localparam logic [7:0]         CHROMA_OFS = 8'd128;

endpackage

@@ hdl/yrdb_if.sv @@
// ----------------------------------------------------------------------------
// yrdb_if: valid/ready channels of the YUV420 rotate/downscale BGRA block
// One interface for the 2x2 block input and one for the pixel output.
// ----------------------------------------------------------------------------
interface yrdb_in_if
  import yrdb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] luma_top_left;
  logic [SAMPLE_W-1:0] luma_top_right;
  logic [SAMPLE_W-1:0] luma_bottom_left;
  logic [SAMPLE_W-1:0] luma_bottom_right;
  logic [SAMPLE_W-1:0] chroma_blue;
  logic [SAMPLE_W-1:0] chroma_red;

  modport source (
    output valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    input  ready
  );
  modport sink (
    input  valid, luma_top_left, luma_top_right, luma_bottom_left,
           luma_bottom_right, chroma_blue, chroma_red,
    output ready
  );
endinterface

interface yrdb_out_if
  import yrdb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  pixel_address;
  logic [PIXEL_W-1:0] pixel_bgra;
  logic               frame_last;

  modport source (
    output valid, pixel_address, pixel_bgra, frame_last,
    input  ready
  );
  modport sink (
    input  valid, pixel_address, pixel_bgra, frame_last,
    output ready
  );
endinterface

@@ hdl/yuv420_rotate_downscale_bgra_top.sv @@
// ----------------------------------------------------------------------------
// yuv420_rotate_downscale_bgra_top: 2x2 YUV420 block to one rotated pixel
//
// The input channel takes one 2x2 luma block with its U and V samples per
// transaction, in source raster order of blocks. The output channel gives
// one BGRA pixel per block, with its address in the frame rotated 90
// degrees counter-clockwise and a flag on the last block of the frame.
// The APB port sets source width, source height and output stride; the user
// must write it only while the block is idle; the block does not enforce this.
// The block is a two-register pipeline: an input register that holds the
// averaged luma, chroma and address terms, and an output register; a
// result passes through both in turn. One block is accepted in every
// cycle while the receiver does not stall; the output register is the
// point that limits it. When the receiver stalls, the output register
// holds its transaction and an empty input register still takes one
// more block before ready drops. Reset clears both pipeline valid flags
// and the block position counters, loads the registers with 1280, 720, 360.
// ----------------------------------------------------------------------------
module yuv420_rotate_downscale_bgra_top
  import yrdb_pkg::*;
#(
  parameter int unsigned MAX_SOURCE_WIDTH  = MAX_SOURCE_WIDTH_DEF,
  parameter int unsigned MAX_SOURCE_HEIGHT = MAX_SOURCE_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Streams
  yrdb_in_if.sink               in_s,
  yrdb_out_if.source            out_m
);

  // Block counts and counter widths follow from the frame limits.
  localparam int unsigned COLS_MAX = MAX_SOURCE_WIDTH / 2;
  localparam int unsigned ROWS_MAX = MAX_SOURCE_HEIGHT / 2;
  localparam int unsigned COL_W    = $clog2(COLS_MAX + 1);
  localparam int unsigned ROW_W    = $clog2(ROWS_MAX + 1);
  localparam int unsigned HALF_W   = CFG_W + 1;

  // Configuration registers.
  logic [CFG_W-1:0] src_width_q, src_height_q, stride_q;
  logic             cfg_write;
  reg_idx_e         cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SOURCE_WIDTH_RST;
      src_height_q <= SOURCE_HEIGHT_RST;
      stride_q     <= OUTPUT_STRIDE_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_SOURCE_WIDTH:  src_width_q  <= pwdata[CFG_W-1:0];
        REG_SOURCE_HEIGHT: src_height_q <= pwdata[CFG_W-1:0];
        REG_OUTPUT_STRIDE: stride_q     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      REG_SOURCE_WIDTH:  prdata = APB_DATA_W'(src_width_q);
      REG_SOURCE_HEIGHT: prdata = APB_DATA_W'(src_height_q);
      REG_OUTPUT_STRIDE: prdata = APB_DATA_W'(stride_q);
      default:           prdata = '0;
    endcase
  end

  // Frame size in blocks: halve the size, then clamp to one..limit.
  logic [HALF_W-1:0] half_w, half_h, cols_c, rows_c;
  logic [COL_W-1:0]  cols;
  logic [ROW_W-1:0]  rows;

  assign half_w = HALF_W'(src_width_q[CFG_W-1:1]);
  assign half_h = HALF_W'(src_height_q[CFG_W-1:1]);

  always_comb begin
    if (half_w == '0) begin
      cols_c = HALF_W'(1);
    end else if (half_w > HALF_W'(COLS_MAX)) begin
      cols_c = HALF_W'(COLS_MAX);
    end else begin
      cols_c = half_w;
    end
    if (half_h == '0) begin
      rows_c = HALF_W'(1);
    end else if (half_h > HALF_W'(ROWS_MAX)) begin
      rows_c = HALF_W'(ROWS_MAX);
    end else begin
      rows_c = half_h;
    end
  end

  assign cols = COL_W'(cols_c);
  assign rows = ROW_W'(rows_c);

  // Pipeline handshake.
  logic s0_valid_q, out_valid_q;
  logic in_fire, out_load;

  assign out_load   = !out_valid_q || out_m.ready;
  assign in_s.ready = !s0_valid_q || out_load;
  assign in_fire    = in_s.valid && in_s.ready;

  // Block position and end-of-row / end-of-frame decode.
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              row_end, frame_end;

  assign col_inc   = {1'b0, col_q} + 1'b1;
  assign row_inc   = {1'b0, row_q} + 1'b1;
  assign row_end   = col_inc >= {1'b0, cols};
  assign frame_end = row_end && (row_inc >= {1'b0, rows});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_q <= col_inc[COL_W-1:0];
      end
    end
  end

  // Rounded luma average and rotated output row, computed at the input.
  logic [SAMPLE_W+1:0] luma_sum;
  logic [ADDR_W-1:0]   out_row;

  assign luma_sum = (SAMPLE_W+2)'(in_s.luma_top_left) + (SAMPLE_W+2)'(in_s.luma_top_right)
                  + (SAMPLE_W+2)'(in_s.luma_bottom_left)
                  + (SAMPLE_W+2)'(in_s.luma_bottom_right) + (SAMPLE_W+2)'(2);
  assign out_row  = ADDR_W'(cols) - ADDR_W'(1) - ADDR_W'(col_q);

  // Input register stage.
  logic [SAMPLE_W-1:0] s0_luma_q, s0_u_q, s0_v_q;
  logic [ADDR_W-1:0]   s0_out_row_q;
  logic [ROW_W-1:0]    s0_row_q;
  logic                s0_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_s.ready) begin
      s0_valid_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_luma_q    <= luma_sum[SAMPLE_W+1:2];
      s0_u_q       <= in_s.chroma_blue;
      s0_v_q       <= in_s.chroma_red;
      s0_out_row_q <= out_row;
      s0_row_q     <= row_q;
      s0_last_q    <= frame_end;
    end
  end

  // Round, drop the fraction and clamp one channel to 0..255.
  function automatic logic [7:0] clamp_channel(input logic signed [19:0] sum);
    logic signed [19:0] rnd;
    logic signed [11:0] shifted;
    rnd     = sum + 20'sd128;
    shifted = 12'(rnd >>> 8);
    if (rnd < 0) begin
      return 8'd0;
    end else if (shifted > 12'sd255) begin
      return 8'd255;
    end else begin
      return shifted[7:0];
    end
  endfunction

  // Color conversion.
  logic signed [19:0] c_y, d_u, e_v;
  logic signed [19:0] sum_r, sum_g, sum_b;
  logic [7:0]         red, green, blue;

  assign c_y = 20'(signed'({2'b00, s0_luma_q}) - signed'({2'b00, LUMA_OFS}));
  assign d_u = 20'(signed'({2'b00, s0_u_q}) - signed'({2'b00, CHROMA_OFS}));
  assign e_v = 20'(signed'({2'b00, s0_v_q}) - signed'({2'b00, CHROMA_OFS}));

  assign sum_r = 20'(COEF_Y * c_y + COEF_RV * e_v);
  assign sum_g = 20'(COEF_Y * c_y - COEF_GU * d_u - COEF_GV * e_v);
  assign sum_b = 20'(COEF_Y * c_y + COEF_BU * d_u);

  assign red   = clamp_channel(sum_r);
  assign green = clamp_channel(sum_g);
  assign blue  = clamp_channel(sum_b);

  // Rotated address, modulo the address width.
  logic [ADDR_W+CFG_W-1:0] row_times_stride;
  logic [ADDR_W-1:0]       pixel_addr;

  assign row_times_stride = (ADDR_W+CFG_W)'(s0_out_row_q) * (ADDR_W+CFG_W)'(stride_q);
  assign pixel_addr       = row_times_stride[ADDR_W-1:0] + ADDR_W'(s0_row_q);

  // Output register stage.
  logic [ADDR_W-1:0]  out_addr_q;
  logic [PIXEL_W-1:0] out_pixel_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s0_valid_q) begin
      out_addr_q  <= pixel_addr;
      out_pixel_q <= {ALPHA, red, green, blue};
      out_last_q  <= s0_last_q;
    end
  end

  assign out_m.valid         = out_valid_q;
  assign out_m.pixel_address = out_addr_q;
  assign out_m.pixel_bgra    = out_pixel_q;
  assign out_m.frame_last    = out_last_q;

endmodule

@@ hdl/yrdb_checker.sv @@
// ----------------------------------------------------------------------------
// yrdb_checker: port-level assertions for the rotate/downscale BGRA block
// Checks output handshake rules, pipeline latency and input ready.
// ----------------------------------------------------------------------------
module yrdb_checker
  import yrdb_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ADDR_W-1:0]  out_addr,
  input logic [PIXEL_W-1:0] out_pixel,
  input logic               out_last
);

  // A stalled output transaction stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // A stalled output transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_addr) && $stable(out_pixel)
                                && $stable(out_last))
    else $error("output payload changed while stalled");

  // Every accepted block is followed by a valid output after the input and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted block did not reach the output");

  // With the output register empty, the input is never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

endmodule

bind yuv420_rotate_downscale_bgra_top yrdb_checker u_yrdb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_addr  (out_m.pixel_address),
  .out_pixel (out_m.pixel_bgra),
  .out_last  (out_m.frame_last)
);
